>>> rtl/core/dcaf_pkg.sv
// Shared types, codes and constants of the drift-correcting audio frame FIFO.
`default_nettype none
package dcaf_pkg;

    localparam int FIFO_FRAMES_DEF = 1024;
    localparam int PRIME_W         = 10;
    localparam int PRIME_RESET     = 512;
    localparam int PHASE_W         = 16;
    localparam int PHASE_ONE       = 65536;
    localparam int CORR_MAX        = 65536 / 50;
    localparam int SAMPLE_W        = 32;
    localparam int FILL_W          = 11;
    // Correction divider: |err| * CORR_MAX over prime_frames
    localparam int DIV_NUM_W       = 21;
    localparam int DIV_QUO_W       = 11;
    localparam int CORR_W          = DIV_QUO_W + 1;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_EMITTED   = 3'd2,
        ST_PRIMING   = 3'd3,
        ST_UNDERRUN  = 3'd4
    } t_status;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } t_in_req;

    typedef struct packed {
        logic [2:0]                 status;
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic [FILL_W-1:0]          fill_level;
        logic                       is_primed;
    } t_out_res;

    // Controller to datapath
    typedef struct packed {
        logic cap_req;
        logic rd_next;
        logic lat_s0;
        logic lat_s1;
        logic div_start;
        logic mul;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic short_path;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

>>> rtl/core/dcaf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dcaf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/dcaf_div.sv
// Restoring divider for the drift correction, one quotient bit per cycle.
`default_nettype none
module dcaf_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [dcaf_pkg::DIV_NUM_W-1:0]    i_num,
    input  wire logic [dcaf_pkg::PRIME_W-1:0]      i_den,
    output logic                                   o_busy,
    output logic      [dcaf_pkg::DIV_QUO_W-1:0]    o_quo
);

    localparam int QW = dcaf_pkg::DIV_QUO_W;
    localparam int DW = dcaf_pkg::PRIME_W;
    localparam int CNTW = $clog2(QW + 1);

    // Quotient fits in QW bits, so the top bits of the numerator start as remainder.
    logic [DW-1:0]   r_rem;
    logic [QW-1:0]   r_shift;
    logic [DW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt;
    logic [DW:0]     trial;
    logic            fits;

    assign trial = {r_rem, r_shift[QW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            o_busy <= 1'b1;
            r_cnt  <= CNTW'(QW);
        end else if (o_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            o_busy <= r_cnt != CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_num[dcaf_pkg::DIV_NUM_W-1 -: DW];
            r_shift <= i_num[QW-1:0];
            r_den   <= i_den;
        end else if (o_busy) begin
            r_rem   <= fits ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
            r_shift <= {r_shift[QW-2:0], fits};
        end
    end

    assign o_quo = r_shift;

endmodule
`default_nettype wire

>>> rtl/core/dcaf_datapath.sv
// FIFO pointers, phase accumulator, step and interpolation datapath.
`default_nettype none
module dcaf_datapath #(
    parameter int FIFO_FRAMES = dcaf_pkg::FIFO_FRAMES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dcaf_pkg::PRIME_W-1:0]  i_cfg_data,
    input  wire dcaf_pkg::t_in_req             i_in_req,
    input  wire logic                          i_out_stall,
    input  wire dcaf_pkg::t_cmd                i_cmd,
    output dcaf_pkg::t_stat                    o_stat,
    output logic                               o_out_valid,
    output dcaf_pkg::t_out_res                 o_out_res
);

    localparam int AW  = $clog2(FIFO_FRAMES);
    localparam int CW  = $clog2(FIFO_FRAMES + 1);
    localparam int TW  = CW + 1;
    localparam int EW  = ((CW > dcaf_pkg::PRIME_W) ? CW : dcaf_pkg::PRIME_W) + 2;
    localparam int SW  = dcaf_pkg::SAMPLE_W;
    localparam int PW  = dcaf_pkg::PHASE_W;
    localparam int PSW = PW + 2;
    localparam int PRW = SW + 1 + PW + 1;
    localparam logic [AW-1:0] LAST   = AW'(FIFO_FRAMES - 1);
    localparam logic [CW-1:0] FULL_C = CW'(FIFO_FRAMES);

    dcaf_pkg::t_in_req  r_req;
    dcaf_pkg::t_out_res r_out;
    dcaf_pkg::t_out_res n_out;
    logic [AW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [PW-1:0]     r_phase;
    logic              r_primed;
    logic [dcaf_pkg::PRIME_W-1:0] r_prime;
    logic signed [SW-1:0] r_s0l, r_s0r, r_s1l, r_s1r, r_pl, r_pr;
    logic              r_out_valid;

    // Request classification
    logic is_pull, priming, underrun;
    assign is_pull  = r_req.req_type == dcaf_pkg::REQ_PULL;
    assign priming  = is_pull && !r_primed && (EW'(r_count) < EW'(r_prime));
    assign underrun = is_pull && !priming && (r_count < CW'(2));

    // Push pointers
    logic          full;
    logic [AW-1:0] head_p1, push_head, tail;
    logic [CW-1:0] push_cnt;
    logic [TW-1:0] tail_sum;
    assign head_p1   = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign full      = r_count == FULL_C;
    assign push_head = full ? head_p1 : r_head;
    assign push_cnt  = full ? FULL_C - 1'b1 : r_count;
    assign tail_sum  = TW'(push_head) + TW'(push_cnt);
    assign tail      = (tail_sum >= TW'(FIFO_FRAMES)) ? AW'(tail_sum - TW'(FIFO_FRAMES))
                                                      : AW'(tail_sum);

    // Fill error, clamped to +/- prime
    logic signed [EW-1:0] err, pe, err_c;
    logic [dcaf_pkg::PRIME_W-1:0] err_mag;
    logic [dcaf_pkg::DIV_NUM_W-1:0] div_num;
    logic [dcaf_pkg::DIV_QUO_W-1:0] quo;
    logic div_busy;
    assign pe    = $signed(EW'(r_prime));
    assign err   = $signed(EW'(r_count)) - pe;
    always_comb begin
        priority if (err > pe) begin
            err_c = pe;
        end else if (err < -pe) begin
            err_c = -pe;
        end else begin
            err_c = err;
        end
    end
    assign err_mag = err_c[EW-1] ? dcaf_pkg::PRIME_W'(-err_c)
                                 : dcaf_pkg::PRIME_W'(err_c);
    assign div_num = dcaf_pkg::DIV_NUM_W'(err_mag)
                   * dcaf_pkg::DIV_NUM_W'(dcaf_pkg::CORR_MAX);

    dcaf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_prime),
        .o_busy  (div_busy),
        .o_quo   (quo)
    );

    // Step and phase advance; up to two frames retire per pull
    logic signed [dcaf_pkg::CORR_W-1:0] corr;
    logic [PSW-1:0] psum;
    logic [1:0]     carries;
    logic [AW+1:0]  hsum;
    logic [AW-1:0]  pull_head;
    assign corr = (r_prime == '0) ? '0
                : err_c[EW-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign psum = PSW'(r_phase) + PSW'(dcaf_pkg::PHASE_ONE)
                + {{(PSW - dcaf_pkg::CORR_W){corr[dcaf_pkg::CORR_W-1]}}, corr};
    assign carries   = psum[PSW-1:PW];
    assign hsum      = (AW + 2)'(r_head) + (AW + 2)'(carries);
    assign pull_head = (hsum >= (AW + 2)'(FIFO_FRAMES)) ? AW'(hsum - (AW + 2)'(FIFO_FRAMES))
                                                         : AW'(hsum);

    // Frame store
    logic [2*SW-1:0] rdata;
    logic            ram_we;
    assign ram_we = i_cmd.commit && !is_pull;

    dcaf_ram #(
        .WIDTH (2 * SW),
        .DEPTH (FIFO_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail),
        .i_wdata ({r_req.left_in, r_req.right_in}),
        .i_raddr (i_cmd.rd_next ? head_p1 : r_head),
        .o_rdata (rdata)
    );

    // Interpolation products
    logic signed [SW:0]    dl, dr;
    logic signed [PRW-1:0] prod_l, prod_r;
    assign dl     = {r_s1l[SW-1], r_s1l} - {r_s0l[SW-1], r_s0l};
    assign dr     = {r_s1r[SW-1], r_s1r} - {r_s0r[SW-1], r_s0r};
    assign prod_l = dl * $signed({1'b0, r_phase});
    assign prod_r = dr * $signed({1'b0, r_phase});

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_req) begin
            r_req <= i_in_req;
        end
        if (i_cmd.lat_s0) begin
            r_s0l <= rdata[2*SW-1:SW];
            r_s0r <= rdata[SW-1:0];
        end
        if (i_cmd.lat_s1) begin
            r_s1l <= rdata[2*SW-1:SW];
            r_s1r <= rdata[SW-1:0];
        end
        if (i_cmd.mul) begin
            r_pl <= prod_l[PW +: SW];
            r_pr <= prod_r[PW +: SW];
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    // Result formation
    always_comb begin
        n_out            = '0;
        n_out.is_primed  = r_primed;
        n_out.fill_level = dcaf_pkg::FILL_W'(r_count);
        priority if (!is_pull) begin
            n_out.status     = full ? dcaf_pkg::ST_DROPPED : dcaf_pkg::ST_STORED;
            n_out.fill_level = dcaf_pkg::FILL_W'(push_cnt + 1'b1);
        end else if (priming) begin
            n_out.status     = dcaf_pkg::ST_PRIMING;
        end else if (underrun) begin
            n_out.status     = dcaf_pkg::ST_UNDERRUN;
            n_out.is_primed  = 1'b1;
        end else begin
            n_out.status     = dcaf_pkg::ST_EMITTED;
            n_out.is_primed  = 1'b1;
            n_out.left_out   = r_s0l + r_pl;
            n_out.right_out  = r_s0r + r_pr;
            n_out.fill_level = dcaf_pkg::FILL_W'(r_count - CW'(carries));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_phase     <= '0;
            r_primed    <= 1'b0;
            r_prime     <= dcaf_pkg::PRIME_W'(dcaf_pkg::PRIME_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prime <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                priority if (!is_pull) begin
                    r_head  <= push_head;
                    r_count <= push_cnt + 1'b1;
                end else if (priming) begin
                    r_primed <= r_primed;
                end else if (underrun) begin
                    r_primed <= 1'b1;
                end else begin
                    r_primed <= 1'b1;
                    r_phase  <= psum[PW-1:0];
                    r_head   <= pull_head;
                    r_count  <= r_count - CW'(carries);
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.short_path = !is_pull || priming || underrun;
    assign o_stat.div_busy   = div_busy;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_res         = r_out;

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || !i_out_stall))
        else $error("result committed over an untaken result");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_C)
        else $error("fill count beyond FIFO depth");
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST)
        else $error("head index out of range");
    a_primed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_primed) && $past(i_rst_n) |-> r_primed)
        else $error("primed flag cleared without reset");

endmodule
`default_nettype wire

>>> rtl/core/dcaf_ctrl.sv
// Request sequencer: capture, frame reads, divide, multiply, commit.
`default_nettype none
module dcaf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire dcaf_pkg::t_stat i_stat,
    output logic                 o_in_stall,
    output dcaf_pkg::t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EVAL = 8'b0000_0010,
        S_RDH  = 8'b0000_0100,
        S_RDN  = 8'b0000_1000,
        S_LAT  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_MUL  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.cap_req = i_in_valid;
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_stat.short_path ? S_FIN : S_RDH;
            end
            S_RDH: begin
                // head is the default read address
                o_cmd.div_start = 1'b1;
                n_state = S_RDN;
            end
            S_RDN: begin
                o_cmd.rd_next = 1'b1;
                o_cmd.lat_s0  = 1'b1;
                n_state = S_LAT;
            end
            S_LAT: begin
                o_cmd.lat_s1 = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!i_stat.div_busy) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.commit = i_stat.out_free;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

    a_mul_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul |-> !i_stat.div_busy)
        else $error("products taken while divider still running");
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && i_stat.out_free |=> r_state == S_IDLE)
        else $error("commit did not return to idle");
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

endmodule
`default_nettype wire

>>> rtl/core/drift_correcting_audio_fifo.sv
// Top level of the drift-correcting stereo audio frame FIFO.
// Sequence: push and non-emitting pulls go from capture through evaluation to the
//   commit into the result register; an emitting pull adds two frame-store reads,
//   the correction divide and one multiply stage before commit. A new request is
//   taken only once the controller is back in idle, so requests never overlap.
// Reset (i_rst_n low, synchronous): empty FIFO, phase zero, unprimed, prime target
//   512, no result pending. Frame store contents are not cleared.
`default_nettype none
module drift_correcting_audio_fifo #(
    parameter int FIFO_FRAMES = dcaf_pkg::FIFO_FRAMES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration: prime target, write only
    input  wire logic                          i_cfg_we,
    input  wire logic [dcaf_pkg::PRIME_W-1:0]  i_cfg_data,
    // Request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire dcaf_pkg::t_in_req             i_in_req,
    // Result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output dcaf_pkg::t_out_res                 o_out_res
);

    // The controller only sequences; every stored data value lives in the datapath.
    dcaf_pkg::t_cmd  cmd;
    dcaf_pkg::t_stat stat;

    dcaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The result register frees the request side: a new request is taken while the
    // previous result still waits, and only the commit step waits for it to drain.
    dcaf_datapath #(
        .FIFO_FRAMES (FIFO_FRAMES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_req    (i_in_req),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

endmodule
`default_nettype wire
